// File: design/mwsk_pkg.sv
// ----------------------------------------------------------------------------
// mwsk_pkg
// Shared types and constants for the mecanum slew and kinematics block.
// ----------------------------------------------------------------------------
package mwsk_pkg;

  localparam int WHEELS    = 4;
  localparam int SPEED_W   = 19;
  localparam int ELAPSED_W = 16;
  localparam int DT_W      = 10;
  localparam int ACCEL_W   = 12;
  localparam int STEP_W    = ACCEL_W + DT_W;
  localparam int GAIN_W    = 16;
  localparam int SUM_W     = 22;
  localparam int PROD_W    = GAIN_W + 1 + SUM_W;
  localparam int OUT_W     = 25;
  localparam int RND_BIT   = 16;

  localparam logic [ELAPSED_W-1:0] MAX_VALID_MS = 16'd1000;

  localparam logic [1:0] REG_ACCEL    = 2'd0;
  localparam logic [1:0] REG_INTERVAL = 2'd1;
  localparam logic [1:0] REG_LIN_GAIN = 2'd2;
  localparam logic [1:0] REG_ANG_GAIN = 2'd3;

  localparam logic [ACCEL_W-1:0] ACCEL_RESET    = 12'd48;
  localparam logic [DT_W-1:0]    INTERVAL_RESET = 10'd10;
  localparam logic [GAIN_W-1:0]  LIN_GAIN_RESET = 16'd7028;
  localparam logic [GAIN_W-1:0]  ANG_GAIN_RESET = 16'd13310;

  typedef logic signed [SPEED_W-1:0] speed_t;
  typedef logic signed [OUT_W-1:0]   vel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_SLEW,
    S_SUM,
    S_MUL,
    S_OUT
  } state_t;

  typedef struct packed {
    logic sum_en;
    logic mul_en;
  } merge_ctrl_t;

  localparam speed_t SPEED_MAX = 19'sh3FFFF;
  localparam speed_t SPEED_MIN = 19'sh40000;

  function automatic speed_t neg_sat(input speed_t v);
    speed_t r;
    if (v == SPEED_MIN) begin
      r = SPEED_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

endpackage

// File: design/mwsk_lane.sv
// ----------------------------------------------------------------------------
// mwsk_lane
// One wheel: holds the target and the simulated speed, ramps toward target.
// ----------------------------------------------------------------------------
module mwsk_lane (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  mwsk_pkg::speed_t                     target_in,
  input  logic                                 en,
  input  logic [mwsk_pkg::STEP_W-1:0]          step,
  output mwsk_pkg::speed_t                     speed
);

  mwsk_pkg::speed_t                    target;
  mwsk_pkg::speed_t                    speed_next;
  mwsk_pkg::speed_t                    up_val;
  mwsk_pkg::speed_t                    dn_val;
  logic signed [mwsk_pkg::SPEED_W:0]   diff;
  logic        [mwsk_pkg::SPEED_W:0]   mag;
  logic                                far;

  always_comb begin
    diff   = $signed({target[mwsk_pkg::SPEED_W-1], target})
           - $signed({speed[mwsk_pkg::SPEED_W-1], speed});
    mag    = diff[mwsk_pkg::SPEED_W] ? 20'(-diff) : 20'(diff);
    far    = {2'b00, mag} > step;
    up_val = mwsk_pkg::SPEED_W'($signed({speed[mwsk_pkg::SPEED_W-1], speed})
           + $signed({1'b0, step[mwsk_pkg::SPEED_W-1:0]}));
    dn_val = mwsk_pkg::SPEED_W'($signed({speed[mwsk_pkg::SPEED_W-1], speed})
           - $signed({1'b0, step[mwsk_pkg::SPEED_W-1:0]}));
    if (far) begin
      speed_next = diff[mwsk_pkg::SPEED_W] ? dn_val : up_val;
    end else begin
      speed_next = target;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      target <= target_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= '0;
    end else if (en) begin
      speed <= speed_next;
    end
  end

  a_move_bounded: assert property (@(posedge clk) disable iff (rst)
    en |=> (speed == $past(target)) || (speed == $past(up_val)) ||
           (speed == $past(dn_val)))
    else $error("lane speed moved to an unexpected value");

  a_hold_at_target: assert property (@(posedge clk) disable iff (rst)
    (en && (speed == target)) |=> $stable(speed))
    else $error("lane speed left its target");

endmodule

// File: design/mwsk_merge.sv
// ----------------------------------------------------------------------------
// mwsk_merge
// Combines the four wheel speeds into vx, vy and yaw rate (signed Q25.0).
// ----------------------------------------------------------------------------
module mwsk_merge (
  input  logic                            clk,
  input  mwsk_pkg::merge_ctrl_t           ctrl,
  input  mwsk_pkg::speed_t                speed [mwsk_pkg::WHEELS],
  input  logic [mwsk_pkg::GAIN_W-1:0]     lin_gain,
  input  logic [mwsk_pkg::GAIN_W-1:0]     ang_gain,
  output mwsk_pkg::vel_t                  vel_x,
  output mwsk_pkg::vel_t                  vel_y,
  output mwsk_pkg::vel_t                  yaw_rate
);

  localparam int QW = mwsk_pkg::PROD_W - mwsk_pkg::RND_BIT;

  logic signed [mwsk_pkg::SUM_W-1:0]  w [mwsk_pkg::WHEELS];
  logic signed [mwsk_pkg::SUM_W-1:0]  sum_x;
  logic signed [mwsk_pkg::SUM_W-1:0]  sum_y;
  logic signed [mwsk_pkg::SUM_W-1:0]  sum_z;
  logic signed [mwsk_pkg::PROD_W-1:0] prod_x;
  logic signed [mwsk_pkg::PROD_W-1:0] prod_y;
  logic signed [mwsk_pkg::PROD_W-1:0] prod_z;
  logic signed [mwsk_pkg::PROD_W-1:0] rnd_x;
  logic signed [mwsk_pkg::PROD_W-1:0] rnd_y;
  logic signed [mwsk_pkg::PROD_W-1:0] rnd_z;
  logic signed [mwsk_pkg::PROD_W-1:0] half;

  for (genvar i = 0; i < mwsk_pkg::WHEELS; i++) begin : g_ext
    assign w[i] = mwsk_pkg::SUM_W'(speed[i]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.sum_en) begin
      sum_x <= w[0] + w[1] + w[2] + w[3];
      sum_y <= -w[0] + w[1] + w[2] - w[3];
      sum_z <= -w[0] + w[1] - w[2] + w[3];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_x <= mwsk_pkg::PROD_W'($signed({1'b0, lin_gain})) * mwsk_pkg::PROD_W'(sum_x);
      prod_y <= mwsk_pkg::PROD_W'($signed({1'b0, lin_gain})) * mwsk_pkg::PROD_W'(sum_y);
      prod_z <= mwsk_pkg::PROD_W'($signed({1'b0, ang_gain})) * mwsk_pkg::PROD_W'(sum_z);
    end
  end

  // Round half up and drop 16 fraction bits; the 23-bit result is sign-extended
  // into the 25-bit output, so no saturation is needed.
  always_comb begin
    half     = mwsk_pkg::PROD_W'(1) <<< (mwsk_pkg::RND_BIT - 1);
    rnd_x    = prod_x + half;
    rnd_y    = prod_y + half;
    rnd_z    = prod_z + half;
    vel_x    = mwsk_pkg::OUT_W'($signed(rnd_x[mwsk_pkg::PROD_W-1 -: QW]));
    vel_y    = mwsk_pkg::OUT_W'($signed(rnd_y[mwsk_pkg::PROD_W-1 -: QW]));
    yaw_rate = mwsk_pkg::OUT_W'($signed(rnd_z[mwsk_pkg::PROD_W-1 -: QW]));
  end

endmodule

// File: design/mecanum_wheel_slew_and_kinematics.sv
// ----------------------------------------------------------------------------
// mecanum_wheel_slew_and_kinematics
// Ramps four simulated wheel speeds toward their commands, then applies
// mecanum forward kinematics.
//
//   channel  direction  payload (lsb first)
//   s_*      in         cmd_speed_1..4 (19b each), elapsed_ms (16b), pad to 96
//   m_*      out        vel_x, vel_y, yaw_rate (25b each), act_speed_1..4
//                       (19b each), pad to 152
//   APB      in/out     accel_per_ms @0x0, default_interval_ms @0x4,
//                       linear_gain @0x8, angular_gain @0xC
//
// From acceptance a request passes in order through step multiply, wheel
// lane update, sums, gain multiply, and round and load into the output
// register; the load waits while an earlier result is still untaken.
// One request is in flight at a time; the next is taken once the result is
// in the output register, even while that result waits on m_tready.
// Synchronous reset zeroes the wheel speeds and arms the first-tick interval.
// ----------------------------------------------------------------------------
module mecanum_wheel_slew_and_kinematics (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // cmd_speed_1, cmd_speed_2, cmd_speed_3, cmd_speed_4, elapsed_ms
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [151:0]  m_tdata,   // vel_x, vel_y, yaw_rate, act_speed_1..4
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int SW = mwsk_pkg::SPEED_W;

  mwsk_pkg::state_t                  state;
  mwsk_pkg::state_t                  state_next;
  mwsk_pkg::merge_ctrl_t             merge_ctrl;
  mwsk_pkg::speed_t                  cmd      [mwsk_pkg::WHEELS];
  mwsk_pkg::speed_t                  tgt      [mwsk_pkg::WHEELS];
  mwsk_pkg::speed_t                  speed    [mwsk_pkg::WHEELS];
  mwsk_pkg::vel_t                    vel_x;
  mwsk_pkg::vel_t                    vel_y;
  mwsk_pkg::vel_t                    yaw_rate;
  logic [mwsk_pkg::ACCEL_W-1:0]      accel_per_ms;
  logic [mwsk_pkg::DT_W-1:0]         default_interval_ms;
  logic [mwsk_pkg::GAIN_W-1:0]       linear_gain;
  logic [mwsk_pkg::GAIN_W-1:0]       angular_gain;
  logic [mwsk_pkg::ELAPSED_W-1:0]    elapsed_ms;
  logic [mwsk_pkg::DT_W-1:0]         dt;
  logic [mwsk_pkg::DT_W-1:0]         dt_next;
  logic [mwsk_pkg::STEP_W-1:0]       step;
  logic                              first_tick;
  logic                              accept;
  logic                              lane_en;
  logic                              out_load;
  logic                              cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_per_ms        <= mwsk_pkg::ACCEL_RESET;
      default_interval_ms <= mwsk_pkg::INTERVAL_RESET;
      linear_gain         <= mwsk_pkg::LIN_GAIN_RESET;
      angular_gain        <= mwsk_pkg::ANG_GAIN_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        mwsk_pkg::REG_ACCEL:    accel_per_ms        <= pwdata[mwsk_pkg::ACCEL_W-1:0];
        mwsk_pkg::REG_INTERVAL: default_interval_ms <= pwdata[mwsk_pkg::DT_W-1:0];
        mwsk_pkg::REG_LIN_GAIN: linear_gain         <= pwdata[mwsk_pkg::GAIN_W-1:0];
        mwsk_pkg::REG_ANG_GAIN: angular_gain        <= pwdata[mwsk_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mwsk_pkg::REG_ACCEL:    prdata = 32'(accel_per_ms);
      mwsk_pkg::REG_INTERVAL: prdata = 32'(default_interval_ms);
      mwsk_pkg::REG_LIN_GAIN: prdata = 32'(linear_gain);
      mwsk_pkg::REG_ANG_GAIN: prdata = 32'(angular_gain);
      default:                prdata = '0;
    endcase
  end

  // input decode
  assign accept     = s_tvalid & s_tready;
  assign elapsed_ms = s_tdata[mwsk_pkg::WHEELS*SW +: mwsk_pkg::ELAPSED_W];

  for (genvar i = 0; i < mwsk_pkg::WHEELS; i++) begin : g_cmd
    assign cmd[i] = s_tdata[i*SW +: SW];
    if (i == 0 || i == 2) begin : g_neg
      assign tgt[i] = mwsk_pkg::neg_sat(cmd[i]);
    end else begin : g_pos
      assign tgt[i] = cmd[i];
    end
  end

  always_comb begin
    if (first_tick || elapsed_ms == '0 || elapsed_ms > mwsk_pkg::MAX_VALID_MS) begin
      dt_next = default_interval_ms;
    end else begin
      dt_next = elapsed_ms[mwsk_pkg::DT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_tick <= 1'b1;
    end else if (accept) begin
      first_tick <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dt <= dt_next;
    end
    if (state == mwsk_pkg::S_STEP) begin
      step <= mwsk_pkg::STEP_W'(accel_per_ms) * mwsk_pkg::STEP_W'(dt);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwsk_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      mwsk_pkg::S_IDLE: state_next = accept ? mwsk_pkg::S_STEP : mwsk_pkg::S_IDLE;
      mwsk_pkg::S_STEP: state_next = mwsk_pkg::S_SLEW;
      mwsk_pkg::S_SLEW: state_next = mwsk_pkg::S_SUM;
      mwsk_pkg::S_SUM:  state_next = mwsk_pkg::S_MUL;
      mwsk_pkg::S_MUL:  state_next = mwsk_pkg::S_OUT;
      mwsk_pkg::S_OUT:  state_next = out_load ? mwsk_pkg::S_IDLE : mwsk_pkg::S_OUT;
      default:          state_next = mwsk_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready          = 1'b0;
    lane_en           = 1'b0;
    merge_ctrl.sum_en = 1'b0;
    merge_ctrl.mul_en = 1'b0;
    out_load          = 1'b0;
    case (state)
      mwsk_pkg::S_IDLE: s_tready          = 1'b1;
      mwsk_pkg::S_SLEW: lane_en           = 1'b1;
      mwsk_pkg::S_SUM:  merge_ctrl.sum_en = 1'b1;
      mwsk_pkg::S_MUL:  merge_ctrl.mul_en = 1'b1;
      mwsk_pkg::S_OUT:  out_load          = !m_tvalid || m_tready;
      default: ;
    endcase
  end

  // wheel lanes
  for (genvar i = 0; i < mwsk_pkg::WHEELS; i++) begin : g_lane
    mwsk_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .load      (accept),
      .target_in (tgt[i]),
      .en        (lane_en),
      .step      (step),
      .speed     (speed[i])
    );
  end

  mwsk_merge u_merge (
    .clk      (clk),
    .ctrl     (merge_ctrl),
    .speed    (speed),
    .lin_gain (linear_gain),
    .ang_gain (angular_gain),
    .vel_x    (vel_x),
    .vel_y    (vel_y),
    .yaw_rate (yaw_rate)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, speed[3], speed[2], speed[1], speed[0],
                  yaw_rate, vel_y, vel_x};
    end
  end

  a_first_cleared: assert property (@(posedge clk) disable iff (rst)
    accept |=> !first_tick)
    else $error("first tick flag not cleared after a request");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##5 (state == mwsk_pkg::S_OUT))
    else $error("request did not reach the output stage on time");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == mwsk_pkg::S_OUT))
    else $error("result presented outside the output stage");

endmodule
